FILE: sv/psed_pkg.sv
package psed_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int EVENT_COUNT = 128;
  localparam int MASK_BITS   = 32;

  // Fixed field widths
  localparam int REQ_W   = 2;
  localparam int EVENT_W = 7;
  localparam int MOD_W   = 6;
  localparam int VALUE_W = 32;
  localparam int OMASK_W = 32;
  localparam int ELIM_W  = 8;
  localparam int MLIM_W  = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam int QA_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int EA_W   = (EVENT_COUNT > 1) ? $clog2(EVENT_COUNT) : 1;
  localparam int MB_W   = (MASK_BITS > 1) ? $clog2(MASK_BITS) : 1;

  // Command queue between front and back
  localparam int CQ_DEPTH = 4;
  localparam int CQA_W    = $clog2(CQ_DEPTH);
  localparam int CQC_W    = $clog2(CQ_DEPTH + 1);

  // Request codes
  localparam logic [REQ_W-1:0] REQ_SUB  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PUB  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DISP = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_EVENTS_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULES_LIMIT = 2'd1;

  // Command kinds
  localparam logic [1:0] CMD_SUB  = 2'd0;
  localparam logic [1:0] CMD_PUB  = 2'd1;
  localparam logic [1:0] CMD_DISP = 2'd2;

  typedef logic [MASK_BITS-1:0] mask_t;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [EVENT_W-1:0] event_id;
    logic [MOD_W-1:0]   module_id;
    logic [VALUE_W-1:0] event_value;
  } in_item_t;

  typedef struct packed {
    logic [OMASK_W-1:0] subscriber_mask;
    logic [EVENT_W-1:0] out_event;
    logic [VALUE_W-1:0] out_value;
  } out_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [EVENT_W-1:0] event_id;
    logic [MB_W-1:0]    bit_idx;
    logic [VALUE_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [EVENT_W-1:0] event_id;
    logic [VALUE_W-1:0] value;
  } qent_t;

  function automatic logic event_ok(input logic [EVENT_W-1:0] ev,
                                    input logic [ELIM_W-1:0]  lim);
    event_ok = (ev != '0) && ({{(ELIM_W-EVENT_W){1'b0}}, ev} < lim);
  endfunction

  function automatic logic [QA_W-1:0] qptr_inc(input logic [QA_W-1:0] p);
    if (p == QA_W'(QUEUE_DEPTH - 1)) begin
      qptr_inc = '0;
    end else begin
      qptr_inc = p + 1'b1;
    end
  endfunction

endpackage

FILE: sv/psed_ram.sv
module psed_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/psed_front.sv
module psed_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  psed_pkg::in_item_t         in_item,
  input  logic [psed_pkg::ELIM_W-1:0] events_limit,
  input  logic [psed_pkg::MLIM_W-1:0] modules_limit,
  output logic                       cmd_valid,
  output psed_pkg::cmd_t             cmd,
  input  logic                       cmd_pop
);
  import psed_pkg::*;

  cmd_t              cq_r [CQ_DEPTH];
  logic [CQA_W-1:0]  wr_r, wr_nxt;
  logic [CQA_W-1:0]  rd_r, rd_nxt;
  logic [CQC_W-1:0]  cnt_r, cnt_nxt;

  logic              accept;
  logic              keep;
  logic              sub_ok;
  logic [MOD_W-1:0]  mod_m1;
  cmd_t              cmd_new;
  logic              do_pop;

  assign in_full   = (cnt_r == CQC_W'(CQ_DEPTH));
  assign accept    = in_push && !in_full;
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = cq_r[rd_r];
  assign do_pop    = cmd_pop && cmd_valid;
  assign mod_m1    = in_item.module_id - 1'b1;

  // Subscribe checks depend only on configuration, so settle them here
  always_comb begin
    sub_ok = (in_item.module_id != '0) &&
             (in_item.module_id < modules_limit) &&
             event_ok(in_item.event_id, events_limit) &&
             (int'(in_item.event_id) < EVENT_COUNT) &&
             (int'(mod_m1) < MASK_BITS);
    cmd_new.event_id = in_item.event_id;
    cmd_new.bit_idx  = MB_W'(mod_m1);
    cmd_new.value    = in_item.event_value;
    cmd_new.kind     = CMD_SUB;
    keep             = 1'b0;
    case (in_item.req_type)
      REQ_SUB: begin
        cmd_new.kind = CMD_SUB;
        keep         = sub_ok;
      end
      REQ_PUB: begin
        cmd_new.kind = CMD_PUB;
        keep         = 1'b1;
      end
      REQ_DISP: begin
        cmd_new.kind = CMD_DISP;
        keep         = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (accept && keep) begin
      wr_nxt = wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = rd_r + 1'b1;
    end
    if ((accept && keep) && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!(accept && keep) && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      cq_r[wr_r] <= cmd_new;
    end
  end

endmodule

FILE: sv/psed_back.sv
module psed_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cmd_valid,
  input  psed_pkg::cmd_t              cmd,
  output logic                        cmd_pop,
  input  logic [psed_pkg::ELIM_W-1:0] events_limit,
  output logic                        out_empty,
  input  logic                        out_pop,
  output psed_pkg::out_item_t         out_item
);
  import psed_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SUB_RD = 2'd1;
  localparam logic [1:0] ST_DQ_RD  = 2'd2;
  localparam logic [1:0] ST_DT_RD  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [QA_W-1:0]   head_r, head_nxt;
  logic [QA_W-1:0]   tail_r, tail_nxt;
  logic [QC_W-1:0]   cnt_r, cnt_nxt;
  logic [EVENT_COUNT-1:0] tvalid_r;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  logic              q_we, q_re;
  qent_t             q_wdata, q_rdata;
  logic              t_we, t_re;
  logic [EA_W-1:0]   t_waddr, t_raddr;
  mask_t             t_wdata, t_rdata;
  mask_t             t_old;
  logic              q_in_range;
  mask_t             disp_mask;

  assign q_wdata.event_id = cmd.event_id;
  assign q_wdata.value    = cmd.value;
  assign t_waddr          = EA_W'(cmd_r.event_id);
  assign t_old            = tvalid_r[t_waddr] ? t_rdata : '0;
  assign t_wdata          = t_old | (mask_t'(1) << cmd_r.bit_idx);
  assign q_in_range       = (int'(q_rdata.event_id) < EVENT_COUNT);
  assign disp_mask        = (q_in_range && tvalid_r[EA_W'(q_rdata.event_id)]) ?
                            t_rdata : '0;

  psed_ram #(.WIDTH($bits(qent_t)), .DEPTH(QUEUE_DEPTH)) u_qram (
    .clk   (clk),
    .we    (q_we),
    .waddr (tail_r),
    .wdata (q_wdata),
    .re    (q_re),
    .raddr (head_r),
    .rdata (q_rdata)
  );

  psed_ram #(.WIDTH(MASK_BITS), .DEPTH(EVENT_COUNT)) u_tram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .re    (t_re),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    cmd_pop       = 1'b0;
    q_we          = 1'b0;
    q_re          = 1'b0;
    t_we          = 1'b0;
    t_re          = 1'b0;
    t_raddr       = EA_W'(cmd.event_id);

    if (out_pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind)
            CMD_SUB: begin
              cmd_pop   = 1'b1;
              cmd_nxt   = cmd;
              t_re      = 1'b1;
              state_nxt = ST_SUB_RD;
            end
            CMD_PUB: begin
              cmd_pop = 1'b1;
              // drop the beat when the ring is full
              if (cnt_r != QC_W'(QUEUE_DEPTH)) begin
                q_we     = 1'b1;
                tail_nxt = qptr_inc(tail_r);
                cnt_nxt  = cnt_r + 1'b1;
              end
            end
            CMD_DISP: begin
              // hold until the result register is free
              if (!out_valid_r) begin
                cmd_pop = 1'b1;
                if (cnt_r != '0) begin
                  q_re      = 1'b1;
                  state_nxt = ST_DQ_RD;
                end
              end
            end
            default: begin
              cmd_pop = 1'b1;
            end
          endcase
        end
      end
      ST_SUB_RD: begin
        t_we      = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_DQ_RD: begin
        t_raddr = EA_W'(q_rdata.event_id);
        if (event_ok(q_rdata.event_id, events_limit)) begin
          t_re      = 1'b1;
          state_nxt = ST_DT_RD;
        end else begin
          // invalid head event: stall the ring, change nothing
          state_nxt = ST_IDLE;
        end
      end
      ST_DT_RD: begin
        out_valid_nxt                = 1'b1;
        out_item_nxt.subscriber_mask = OMASK_W'(disp_mask);
        out_item_nxt.out_event       = q_rdata.event_id;
        out_item_nxt.out_value       = q_rdata.value;
        head_nxt                     = qptr_inc(head_r);
        cnt_nxt                      = cnt_r - 1'b1;
        state_nxt                    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      tvalid_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (t_we) begin
        tvalid_r[t_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: sv/pubsub_event_dispatcher_top.sv
// Channel   Handshake          Payload
// in_       in_push / in_full   in_item (req_type, event_id, module_id, event_value)
// out_      out_pop / out_empty out_item (subscriber_mask, out_event, out_value)
// cfg_      cfg_valid/cfg_ready cfg_index, cfg_data
//
// Requests pass a 4-entry command queue; the back end runs one at a time.
// Publish is done from idle; subscribe is a read-modify-write of the mask table RAM;
// dispatch reads the ring RAM, then the mask table, in the back end's sequencer.
// Reset clears pointers, counts and the per-event valid bits of the mask table.
// A dispatch waits while the result register is still occupied and holds the
// requests queued behind it; in_full rises when the command queue fills.
module pubsub_event_dispatcher_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  psed_pkg::in_item_t             in_item,
  output logic                           out_empty,
  input  logic                           out_pop,
  output psed_pkg::out_item_t            out_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [psed_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [psed_pkg::CFG_DATA_W-1:0] cfg_data
);
  import psed_pkg::*;

  logic [ELIM_W-1:0] events_limit_r;
  logic [MLIM_W-1:0] modules_limit_r;
  logic              cmd_valid;
  logic              cmd_pop;
  cmd_t              cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      events_limit_r  <= '0;
      modules_limit_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_EVENTS_LIMIT:  events_limit_r  <= ELIM_W'(cfg_data);
        CFG_MODULES_LIMIT: modules_limit_r <= MLIM_W'(cfg_data);
        default: begin
        end
      endcase
    end
  end

  psed_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_item       (in_item),
    .events_limit  (events_limit_r),
    .modules_limit (modules_limit_r),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  psed_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop),
    .events_limit (events_limit_r),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_item     (out_item)
  );

endmodule

FILE: dv/pubsub_event_dispatcher_top_tb.sv
module pubsub_event_dispatcher_top_tb;
  import psed_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int RANDOM_PHASES = 23;
  localparam int PHASE_ITEMS   = 80;
  localparam int BURST_ITEMS   = 40;
  localparam int HOLD_CYCLES   = 400;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_push = 1'b0;
  logic                  in_full;
  in_item_t              in_item = '0;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pubsub_event_dispatcher_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Mirror of the dispatcher state
  logic [ELIM_W-1:0]  lim_events = '0;
  logic [MLIM_W-1:0]  lim_modules = '0;
  mask_t              sub_masks [EVENT_COUNT];
  logic [EVENT_W-1:0] ring_event [QUEUE_DEPTH];
  logic [VALUE_W-1:0] ring_value [QUEUE_DEPTH];
  logic [QA_W-1:0]    ring_head = '0;
  logic [QA_W-1:0]    ring_tail = '0;
  logic               ring_room = 1'b1;

  in_item_t  send_q[$];
  out_item_t due_q[$];

  int   fails = 0;
  int   cycle_cnt = 0;
  int   in_gap_max = 0;
  int   out_gap_max = 0;
  int   in_wait = 0;
  int   out_wait = 0;
  int   hold_left = 0;
  logic in_took = 1'b0;
  logic out_took = 1'b0;

  function automatic logic ev_live(logic [EVENT_W-1:0] ev);
    return (ev != '0) && ({1'b0, ev} < lim_events);
  endfunction

  function automatic logic [QA_W-1:0] ring_next(logic [QA_W-1:0] p);
    return (int'(p) == QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  task automatic report(string msg);
    if (fails < 100) begin
      $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    end
    fails++;
  endtask

  task automatic apply_request(in_item_t r);
    out_item_t res;
    int        bit_pos;
    bit_pos = int'(r.module_id) - 1;
    case (r.req_type)
      REQ_SUB: begin
        if (r.module_id != '0 && r.module_id < lim_modules && ev_live(r.event_id) &&
            bit_pos < MASK_BITS) begin
          sub_masks[r.event_id][bit_pos] = 1'b1;
        end
      end
      REQ_PUB: begin
        // drop when the ring is full
        if (ring_room) begin
          ring_event[ring_tail] = r.event_id;
          ring_value[ring_tail] = r.event_value;
          ring_tail = ring_next(ring_tail);
          if (ring_tail == ring_head) ring_room = 1'b0;
        end
      end
      REQ_DISP: begin
        // an empty or out-of-range head stalls the ring
        if (ev_live(ring_event[ring_head])) begin
          res.subscriber_mask = sub_masks[ring_event[ring_head]];
          res.out_event       = ring_event[ring_head];
          res.out_value       = ring_value[ring_head];
          due_q.push_back(res);
          ring_event[ring_head] = '0;
          ring_value[ring_head] = '0;
          ring_head = ring_next(ring_head);
          ring_room = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (due_q.size() == 0) begin
      report($sformatf("unexpected dispatch event %0d value %h mask %h",
                       got.out_event, got.out_value, got.subscriber_mask));
    end else begin
      want = due_q.pop_front();
      if (got.subscriber_mask !== want.subscriber_mask)
        report($sformatf("subscriber_mask %h, want %h (event %0d)",
                         got.subscriber_mask, want.subscriber_mask, want.out_event));
      if (got.out_event !== want.out_event)
        report($sformatf("out_event %0d, want %0d", got.out_event, want.out_event));
      if (got.out_value !== want.out_value)
        report($sformatf("out_value %h, want %h (event %0d)",
                         got.out_value, want.out_value, want.out_event));
    end
  endtask

  always @(posedge clk) begin
    in_took  = rst_n && in_push && !in_full;
    out_took = rst_n && out_pop && !out_empty;
    if (in_took) apply_request(in_item);
    if (out_took) check_result(out_item);
  end

  // Sender: hold the beat until taken, then wait the drawn gap
  always @(negedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else if (!in_push || in_took) begin
      if (in_wait > 0) begin
        in_wait--;
        in_push <= 1'b0;
      end else if (send_q.size() > 0) begin
        in_item <= send_q.pop_front();
        in_push <= 1'b1;
        in_wait = $urandom_range(0, in_gap_max);
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // Receiver: draw a gap after each beat; a long hold overrides everything
  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_took) out_wait = $urandom_range(0, out_gap_max);
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (out_wait > 0) begin
        out_wait--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb: failure");
    $finish;
  end

  task automatic queue_req(logic [REQ_W-1:0] req, int ev, int mod, logic [31:0] val);
    in_item_t r;
    r.req_type    = req;
    r.event_id    = EVENT_W'(ev);
    r.module_id   = MOD_W'(mod);
    r.event_value = val;
    send_q.push_back(r);
  endtask

  function automatic in_item_t random_request();
    in_item_t r;
    int       pick;
    pick          = $urandom_range(0, 99);
    r.event_id    = EVENT_W'($urandom_range(0, 127));
    r.module_id   = MOD_W'($urandom_range(0, 32));
    r.event_value = $urandom;
    if (pick < 3) begin
      r.req_type  = REQ_UNUSED;
      r.module_id = MOD_W'($urandom_range(0, 63));
    end else if (pick < 33) begin
      r.req_type = REQ_SUB;
      if ($urandom_range(0, 99) < 85) begin
        if (lim_events >= 2) r.event_id = EVENT_W'($urandom_range(1, int'(lim_events) - 1));
        if (lim_modules >= 2) r.module_id = MOD_W'($urandom_range(1, int'(lim_modules) - 1));
      end
    end else if (pick < 66) begin
      r.req_type = REQ_PUB;
      // never publish event 0 here: it would stall the ring for good
      if (lim_events >= 2 && $urandom_range(0, 9) != 0)
        r.event_id = EVENT_W'($urandom_range(1, int'(lim_events) - 1));
      else
        r.event_id = EVENT_W'($urandom_range(1, 127));
    end else begin
      r.req_type = REQ_DISP;
    end
    return r;
  endfunction

  task automatic settle();
    while (send_q.size() != 0 || in_push || due_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(data);
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_EVENTS_LIMIT) lim_events = ELIM_W'(data);
    else if (idx == CFG_MODULES_LIMIT) lim_modules = MLIM_W'(data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_limits(int ev_lim, int mod_lim);
    settle();
    write_reg(CFG_EVENTS_LIMIT, ev_lim);
    write_reg(CFG_MODULES_LIMIT, mod_lim);
  endtask

  function automatic int pick_gap_max();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 4;
      default: return 19;
    endcase
  endfunction

  initial begin
    in_item_t r;
    int       ev_lim;
    int       mod_lim;
    int       n;
    int       waited;

    for (int i = 0; i < EVENT_COUNT; i++) sub_masks[i] = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ring_event[i] = '0;
      ring_value[i] = '0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Limits at reset: everything ignored or stalled
    queue_req(REQ_SUB, 5, 1, 32'h0);
    queue_req(REQ_PUB, 5, 0, 32'hFFFF_FFFF);
    queue_req(REQ_DISP, 0, 0, 32'h0);
    queue_req(REQ_UNUSED, 127, 63, 32'hFFFF_FFFF);

    set_limits(128, 33);
    queue_req(REQ_SUB, 5, 1, 32'h0);
    queue_req(REQ_SUB, 5, 32, 32'h0);
    queue_req(REQ_SUB, 127, 31, 32'h0);
    queue_req(REQ_SUB, 0, 3, 32'h0);
    queue_req(REQ_SUB, 5, 0, 32'h0);
    queue_req(REQ_SUB, 127, 33, 32'h0);
    queue_req(REQ_DISP, 0, 0, 32'h0);
    queue_req(REQ_PUB, 127, 0, 32'h0);
    queue_req(REQ_PUB, 1, 0, 32'hA5A5_A5A5);
    queue_req(REQ_DISP, 0, 0, 32'h0);
    queue_req(REQ_DISP, 0, 0, 32'h0);
    queue_req(REQ_DISP, 0, 0, 32'h0);
    // mask is read at dispatch time, so a late subscriber still counts
    queue_req(REQ_PUB, 42, 0, 32'h1234_5678);
    queue_req(REQ_SUB, 42, 16, 32'h0);
    queue_req(REQ_DISP, 0, 0, 32'h0);

    // Modules past the mask width, and a head event over the limit
    set_limits(10, 63);
    queue_req(REQ_SUB, 3, 40, 32'h0);
    queue_req(REQ_SUB, 3, 33, 32'h0);
    queue_req(REQ_SUB, 3, 1, 32'h0);
    queue_req(REQ_SUB, 12, 2, 32'h0);
    queue_req(REQ_PUB, 50, 0, 32'hDEAD_BEEF);
    queue_req(REQ_PUB, 3, 0, 32'h0000_0001);
    queue_req(REQ_DISP, 0, 0, 32'h0);
    set_limits(128, 33);
    queue_req(REQ_DISP, 0, 0, 32'h0);
    queue_req(REQ_DISP, 0, 0, 32'h0);

    // Overfill the ring, then dispatch while the receiver holds off
    settle();
    in_gap_max  = 0;
    out_gap_max = 0;
    for (int i = 0; i < BURST_ITEMS; i++) queue_req(REQ_PUB, $urandom_range(1, 127), 0, $urandom);
    settle();
    hold_left = HOLD_CYCLES;
    for (int i = 0; i < BURST_ITEMS; i++) queue_req(REQ_DISP, 0, 0, $urandom);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 9))
        0:       ev_lim = 0;
        1:       ev_lim = 1;
        2:       ev_lim = 2;
        3, 4, 5: ev_lim = 128;
        default: ev_lim = $urandom_range(3, 127);
      endcase
      case ($urandom_range(0, 9))
        0:       mod_lim = 0;
        1:       mod_lim = 1;
        2:       mod_lim = 63;
        3, 4, 5: mod_lim = 33;
        default: mod_lim = $urandom_range(2, 32);
      endcase
      settle();
      in_gap_max  = pick_gap_max();
      out_gap_max = pick_gap_max();
      set_limits(ev_lim, mod_lim);
      n = 0;
      while (n < PHASE_ITEMS) begin
        r = random_request();
        send_q.push_back(r);
        if (r.req_type != REQ_UNUSED) n++;
      end
    end

    // Drain everything, then leave event 0 at the head
    set_limits(128, 33);
    for (int i = 0; i < QUEUE_DEPTH + 2; i++) queue_req(REQ_DISP, 0, 0, 32'h0);
    queue_req(REQ_PUB, 0, 0, $urandom);
    queue_req(REQ_DISP, 0, 0, 32'h0);

    waited = 0;
    while ((send_q.size() != 0 || in_push || due_q.size() != 0) && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (due_q.size() != 0) report($sformatf("%0d dispatches never came out", due_q.size()));
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
